// ----- design/r2y_pkg.sv -----
// ============================================================================
// r2y_pkg
// Shared types, constants and arithmetic helpers for the RGBA to YCbCr 4:2:0
// converter.
// ============================================================================
package r2y_pkg;

    // Default frame limits handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_RANGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_RB       = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    // Matrix codes.
    localparam logic [1:0] MAT_BT601  = 2'd0;
    localparam logic [1:0] MAT_BT709  = 2'd1;
    localparam logic [1:0] MAT_BT2020 = 2'd2;

    // Field widths.
    localparam int PIX_W    = 8;
    localparam int PAIR_W   = 9;
    localparam int CELL_W   = 11;
    localparam int LINE_W   = 3 * PAIR_W;
    localparam int COEF_W   = 9;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int ACC_W    = 20;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // Decoupling queue between the front and back halves.
    localparam int FIFO_DEPTH = 4;

    localparam logic signed [ACC_W-1:0] ROUND_HALF    = 20'sd128;
    localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 20'sd128;

    typedef logic signed [COEF_W-1:0] coef_t;

    // One coefficient set: Y (R,G,B), Cb (R,G,B), Cr (R,G,B), luma offset.
    typedef struct packed {
        coef_t y_r;
        coef_t y_g;
        coef_t y_b;
        coef_t cb_r;
        coef_t cb_g;
        coef_t cb_b;
        coef_t cr_r;
        coef_t cr_g;
        coef_t cr_b;
        coef_t y_off;
    } coef_set_t;

    // Work item handed from the front to the back through the queue.
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [PIX_W-1:0]  avg_red;
        logic [PIX_W-1:0]  avg_green;
        logic [PIX_W-1:0]  avg_blue;
        logic              chroma_valid;
        logic [CELL_W-1:0] cell_column;
        logic [CELL_W-1:0] cell_row;
        logic              frame_done;
        logic [2:0]        coef_idx;
    } work_item_t;

    // Coefficient index is {matrix, range mode}; the two unused codes fall
    // back to BT.601 limited range.
    function automatic coef_set_t coef_lookup(input logic [2:0] idx);
        coef_set_t c;
        unique case (idx)
            3'd0:    c = '{9'sd66, 9'sd129, 9'sd25, -9'sd38, -9'sd74,
                           9'sd112, 9'sd112, -9'sd94, -9'sd18, 9'sd16};
            3'd1:    c = '{9'sd77, 9'sd150, 9'sd29, -9'sd43, -9'sd85,
                           9'sd128, 9'sd128, -9'sd107, -9'sd21, 9'sd0};
            3'd2:    c = '{9'sd47, 9'sd157, 9'sd16, -9'sd26, -9'sd86,
                           9'sd112, 9'sd112, -9'sd102, -9'sd10, 9'sd16};
            3'd3:    c = '{9'sd54, 9'sd183, 9'sd19, -9'sd29, -9'sd99,
                           9'sd128, 9'sd128, -9'sd116, -9'sd12, 9'sd0};
            3'd4:    c = '{9'sd58, 9'sd149, 9'sd13, -9'sd31, -9'sd81,
                           9'sd112, 9'sd112, -9'sd103, -9'sd9, 9'sd16};
            3'd5:    c = '{9'sd67, 9'sd174, 9'sd15, -9'sd36, -9'sd92,
                           9'sd128, 9'sd128, -9'sd118, -9'sd10, 9'sd0};
            default: c = '{9'sd66, 9'sd129, 9'sd25, -9'sd38, -9'sd74,
                           9'sd112, 9'sd112, -9'sd94, -9'sd18, 9'sd16};
        endcase
        return c;
    endfunction

    // Both operands are widened to the product width before the multiply.
    function automatic logic signed [PROD_W-1:0] mul_pix(input coef_t k,
                                                         input logic [PIX_W-1:0] v);
        logic signed [PROD_W-1:0] wide_k;
        logic signed [PROD_W-1:0] wide_v;
        wide_k = PROD_W'(k);
        wide_v = $signed(PROD_W'(v));
        return wide_k * wide_v;
    endfunction

    // Rounded arithmetic shift by eight, then offset and clip to a byte.
    function automatic logic [PIX_W-1:0] round_clip(input logic signed [PROD_W-1:0] p0,
                                                    input logic signed [PROD_W-1:0] p1,
                                                    input logic signed [PROD_W-1:0] p2,
                                                    input logic signed [ACC_W-1:0] off);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] val;
        acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ROUND_HALF;
        val = (acc >>> 8) + off;
        if (val < 0) begin
            return '0;
        end else if (val > 20'sd255) begin
            return '1;
        end
        return val[PIX_W-1:0];
    endfunction

endpackage

// ----- design/r2y_ram.sv -----
// ============================================================================
// r2y_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module r2y_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/r2y_fifo.sv -----
// ============================================================================
// r2y_fifo
// Short register queue that decouples the front half from the back half.
// ============================================================================
module r2y_fifo
    import r2y_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  work_item_t push_item,
    output logic       full,
    input  logic       pop,
    output work_item_t pop_item,
    output logic       empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    work_item_t       slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_ptr_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_W'(rd_ptr_reg + count_reg) == wr_ptr_reg)
        else $error("queue pointers out of step with count");
`endif

endmodule

// ----- design/r2y_front.sv -----
// ============================================================================
// r2y_front
// Accepts pixels, tracks the raster position, forms the 2x2 cell sums through
// the line store and hands finished work items to the queue.
// ============================================================================
module r2y_front
    import r2y_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  push,
    output work_item_t            push_item,
    input  logic                  fifo_full
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WD_W       = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                                $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int HD_W       = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                                $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [1:0]            matrix_reg;
    logic                  full_swing_reg;
    logic                  swap_reg;

    // Raster position and the held even-column pixel.
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [3*PIX_W-1:0]  held_reg;

    // Stage register between the line store read and the queue push.
    logic                st_valid_reg, st_valid_next;
    logic [PIX_W-1:0]    st_red_reg, st_green_reg, st_blue_reg;
    logic [PAIR_W-1:0]   st_pr_reg, st_pg_reg, st_pb_reg;
    logic                st_chroma_reg;
    logic                st_odd_row_reg;
    logic [CELL_W-1:0]   st_ccol_reg, st_crow_reg;
    logic                st_done_reg;
    logic [2:0]          st_coef_reg;

    logic                accept;
    logic [PIX_W-1:0]    px_r, px_g, px_b;
    logic [WD_W-1:0]     eff_w, w_last;
    logic [HD_W-1:0]     eff_h, h_last;
    logic                last_col, last_row, odd_col, odd_row;
    logic                have_pair, chroma;
    logic [PAIR_W-1:0]   pr, pg, pb;
    logic [LINE_AW-1:0]  line_addr;
    logic                line_we;
    logic [LINE_W-1:0]   line_rdata;
    logic [1:0]          matrix_eff;
    logic [PAIR_W:0]     sum_r, sum_g, sum_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= RST_FRAME_WIDTH;
            height_reg     <= RST_FRAME_HEIGHT;
            matrix_reg     <= MAT_BT601;
            full_swing_reg <= 1'b0;
            swap_reg       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   width_reg      <= cfg_data;
                REG_FRAME_HEIGHT:  height_reg     <= cfg_data;
                REG_MATRIX_SELECT: matrix_reg     <= cfg_data[1:0];
                REG_FULL_RANGE:    full_swing_reg <= cfg_data[0];
                REG_SWAP_RB:       swap_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The stage moves on whenever the queue has room.
    assign push     = st_valid_reg && !fifo_full;
    assign s_tready = !st_valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        px_r = swap_reg ? s_tdata[23:16] : s_tdata[7:0];
        px_g = s_tdata[15:8];
        px_b = swap_reg ? s_tdata[7:0] : s_tdata[23:16];

        if (width_reg == '0) begin
            eff_w = WD_W'(1);
        end else if (WD_W'(width_reg) > WD_W'(MAX_WIDTH)) begin
            eff_w = WD_W'(MAX_WIDTH);
        end else begin
            eff_w = WD_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = HD_W'(1);
        end else if (HD_W'(height_reg) > HD_W'(MAX_HEIGHT)) begin
            eff_h = HD_W'(MAX_HEIGHT);
        end else begin
            eff_h = HD_W'(height_reg);
        end
        w_last = WD_W'(eff_w - 1'b1);
        h_last = HD_W'(eff_h - 1'b1);

        last_col = WD_W'(col_reg) >= w_last;
        last_row = HD_W'(row_reg) >= h_last;
        odd_col  = col_reg[0];
        odd_row  = row_reg[0];

        // Horizontal pair: held even pixel plus this one, or this one twice
        // at the right edge of an odd width.
        if (odd_col) begin
            pr = PAIR_W'(held_reg[23:16]) + PAIR_W'(px_r);
            pg = PAIR_W'(held_reg[15:8])  + PAIR_W'(px_g);
            pb = PAIR_W'(held_reg[7:0])   + PAIR_W'(px_b);
        end else begin
            pr = {px_r, 1'b0};
            pg = {px_g, 1'b0};
            pb = {px_b, 1'b0};
        end
        have_pair = odd_col || last_col;
        chroma    = have_pair && (odd_row || last_row);
        line_we   = accept && have_pair && !odd_row && !last_row;
        line_addr = LINE_AW'(col_reg >> 1);

        matrix_eff = (matrix_reg == MAT_BT709 || matrix_reg == MAT_BT2020) ?
                     matrix_reg : MAT_BT601;
    end

    r2y_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (line_addr),
        .wr_data ({pr, pg, pb}),
        .rd_en   (accept),
        .rd_addr (line_addr),
        .rd_data (line_rdata)
    );

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_reg + 1'b1);
            end else begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
        st_valid_next = accept ? 1'b1 : (push ? 1'b0 : st_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !odd_col) begin
            held_reg <= {px_r, px_g, px_b};
        end
        if (accept) begin
            st_red_reg     <= px_r;
            st_green_reg   <= px_g;
            st_blue_reg    <= px_b;
            st_pr_reg      <= pr;
            st_pg_reg      <= pg;
            st_pb_reg      <= pb;
            st_chroma_reg  <= chroma;
            st_odd_row_reg <= odd_row;
            st_ccol_reg    <= CELL_W'(col_reg >> 1);
            st_crow_reg    <= CELL_W'(row_reg >> 1);
            st_done_reg    <= last_col && last_row;
            st_coef_reg    <= {matrix_eff, full_swing_reg};
        end
    end

    // Vertical sum: stored even-row pair plus this pair, or this pair twice
    // on the last row of an odd height.
    always_comb begin
        if (st_odd_row_reg) begin
            sum_r = (PAIR_W+1)'(line_rdata[26:18]) + (PAIR_W+1)'(st_pr_reg);
            sum_g = (PAIR_W+1)'(line_rdata[17:9])  + (PAIR_W+1)'(st_pg_reg);
            sum_b = (PAIR_W+1)'(line_rdata[8:0])   + (PAIR_W+1)'(st_pb_reg);
        end else begin
            sum_r = {st_pr_reg, 1'b0};
            sum_g = {st_pg_reg, 1'b0};
            sum_b = {st_pb_reg, 1'b0};
        end

        push_item.red          = st_red_reg;
        push_item.green        = st_green_reg;
        push_item.blue         = st_blue_reg;
        push_item.avg_red      = PIX_W'(((PAIR_W+2)'(sum_r) + 2'd2) >> 2);
        push_item.avg_green    = PIX_W'(((PAIR_W+2)'(sum_g) + 2'd2) >> 2);
        push_item.avg_blue     = PIX_W'(((PAIR_W+2)'(sum_b) + 2'd2) >> 2);
        push_item.chroma_valid = st_chroma_reg;
        push_item.cell_column  = st_ccol_reg;
        push_item.cell_row     = st_crow_reg;
        push_item.frame_done   = st_done_reg;
        push_item.coef_idx     = st_coef_reg;
    end

endmodule

// ----- design/r2y_back.sv -----
// ============================================================================
// r2y_back
// Pops work items, forms the coefficient products and drives the registered
// result beat.
// ============================================================================
module r2y_back
    import r2y_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fifo_empty,
    input  work_item_t          pop_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    logic                        p1_valid_reg;
    logic signed [PROD_W-1:0]    y_p_reg  [3];
    logic signed [PROD_W-1:0]    cb_p_reg [3];
    logic signed [PROD_W-1:0]    cr_p_reg [3];
    logic signed [ACC_W-1:0]     y_off_reg;
    logic                        p1_chroma_reg;
    logic [CELL_W-1:0]           p1_ccol_reg, p1_crow_reg;
    logic                        p1_done_reg;

    logic                        out_valid_reg;
    logic [M_DATA_W-1:0]         out_data_reg;
    logic                        out_user_reg;
    logic                        out_last_reg;

    logic                        p1_load, out_load;
    coef_set_t                   k;
    logic [PIX_W-1:0]            luma, cb, cr;

    assign out_load = !out_valid_reg || m_tready;
    assign p1_load  = !p1_valid_reg || out_load;
    assign pop      = !fifo_empty && p1_load;
    assign k        = coef_lookup(pop_item.coef_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (p1_load) begin
                p1_valid_reg <= !fifo_empty;
            end
            if (out_load) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            y_p_reg[0]    <= mul_pix(k.y_r,  pop_item.red);
            y_p_reg[1]    <= mul_pix(k.y_g,  pop_item.green);
            y_p_reg[2]    <= mul_pix(k.y_b,  pop_item.blue);
            cb_p_reg[0]   <= mul_pix(k.cb_r, pop_item.avg_red);
            cb_p_reg[1]   <= mul_pix(k.cb_g, pop_item.avg_green);
            cb_p_reg[2]   <= mul_pix(k.cb_b, pop_item.avg_blue);
            cr_p_reg[0]   <= mul_pix(k.cr_r, pop_item.avg_red);
            cr_p_reg[1]   <= mul_pix(k.cr_g, pop_item.avg_green);
            cr_p_reg[2]   <= mul_pix(k.cr_b, pop_item.avg_blue);
            y_off_reg     <= ACC_W'(k.y_off);
            p1_chroma_reg <= pop_item.chroma_valid;
            p1_ccol_reg   <= pop_item.cell_column;
            p1_crow_reg   <= pop_item.cell_row;
            p1_done_reg   <= pop_item.frame_done;
        end
    end

    always_comb begin
        luma = round_clip(y_p_reg[0], y_p_reg[1], y_p_reg[2], y_off_reg);
        cb   = round_clip(cb_p_reg[0], cb_p_reg[1], cb_p_reg[2], CHROMA_OFFSET);
        cr   = round_clip(cr_p_reg[0], cr_p_reg[1], cr_p_reg[2], CHROMA_OFFSET);
    end

    // Chroma fields read as zero on beats that do not close a cell.
    always_ff @(posedge aclk) begin
        if (out_load && p1_valid_reg) begin
            out_data_reg <= {2'b00,
                             p1_chroma_reg ? p1_crow_reg : {CELL_W{1'b0}},
                             p1_chroma_reg ? p1_ccol_reg : {CELL_W{1'b0}},
                             p1_chroma_reg ? cr : {PIX_W{1'b0}},
                             p1_chroma_reg ? cb : {PIX_W{1'b0}},
                             luma};
            out_user_reg <= p1_chroma_reg;
            out_last_reg <= p1_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- design/rgba_to_yuv420_convert_core.sv -----
// ============================================================================
// rgba_to_yuv420_convert_core
// RGBA/BGRA to YCbCr 4:2:0 streaming converter: per-pixel luma, one Cb/Cr
// pair per 2x2 cell emitted with the pixel that closes the cell.
// ============================================================================
//
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata: byte_zero, byte_one, byte_two
// m_axis    out  m_tvalid/m_tready    m_tdata, m_tuser (chroma_valid),
//                                     m_tlast (frame_done)
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The block sustains one pixel per clock cycle while the result side accepts
// beats. Between its input beat and its result beat a pixel passes the line
// store read stage, the queue, the product register and the output register.
// Reset (aresetn low at a clock edge) clears the raster position, the queue
// and all valid flags and loads the default configuration.
// The line store needs no clearing pass; an odd row only reads entries that
// the even row above it has written.
// A stall on the result side holds the output and product registers, then
// fills the four-entry queue; the input side keeps taking beats until the
// queue and the line store stage are full, so up to seven pixels are in flight.
//
// The front half owns the configuration registers, the raster counters and
// the line store holding the even row's horizontal pair sums. It forms each
// cell's rounded box average. The back half multiplies by the selected
// coefficient set and rounds, offsets and clips the three results.
// ============================================================================
module rgba_to_yuv420_convert_core
    import r2y_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Pixel input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // byte_zero [7:0], byte_one [15:8], byte_two [23:16]
    input  logic [S_DATA_W-1:0]   s_tdata,

    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // luma [7:0], blue_diff [15:8], red_diff [23:16], cell_column [34:24],
    // cell_row [45:35], zero [47:46]
    output logic [M_DATA_W-1:0]   m_tdata,
    // chroma_valid [0]
    output logic                  m_tuser,
    output logic                  m_tlast,

    // Register writes: 0 frame_width, 1 frame_height, 2 matrix_select,
    // 3 range mode (1 selects full swing), 4 swap_red_blue.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic       push;
    logic       pop;
    logic       fifo_full;
    logic       fifo_empty;
    work_item_t push_item;
    work_item_t pop_item;

    // Front half: accepts pixels and builds work items.
    r2y_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    // Queue that lets either half stall without holding up the other until it fills or runs empty.
    r2y_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    // Back half: color matrix arithmetic and the result register.
    r2y_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .pop_item   (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- tb/rgba_to_yuv420_convert_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rgba_to_yuv420_convert_core_tb
// Self-checking testbench for the RGBA to YCbCr 4:2:0 converter. A behavioral
// predictor tracks the raster position, the held even pixel and the line of
// even-row pair sums, and works out the luma, the chroma of each closed 2x2
// cell and the frame end for every pixel beat taken by the block. Every
// result beat is compared field by field with the oldest prediction. Both
// stream sides idle at random. The runs cover the edge cases of frame size,
// the color matrices, full range, byte swap, register writes in the middle
// of a frame and long output stalls.
// ============================================================================
module rgba_to_yuv420_convert_core_tb;
    import r2y_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_SLACK  = 8;
    localparam int MAX_PRINTED  = 100;
    localparam int LINE_SLOTS   = (DEF_MAX_WIDTH + 1) / 2;
    localparam int RANDOM_PIXELS = 350;
    localparam int LONG_ROW     = 131;
    localparam int TALL_COLUMN  = 65;
    localparam int CHROMA_MID   = 128;

    // Matrix code with no table of its own; the block falls back to BT.601.
    localparam logic [1:0] MAT_SPARE = 2'd3;

    // Slots of one coefficient row: Y, Cb and Cr weights for R, G, B, then
    // the luma offset.
    localparam int Y_SLOT      = 0;
    localparam int CB_SLOT     = 3;
    localparam int CR_SLOT     = 6;
    localparam int OFFSET_SLOT = 9;

    typedef struct {
        int          serial;
        logic [7:0]  luma;
        logic        chroma_valid;
        logic [7:0]  blue_diff;
        logic [7:0]  red_diff;
        logic [10:0] cell_column;
        logic [10:0] cell_row;
        logic        frame_done;
    } yuv_result_t;

    // Rows are {matrix, range mode}: BT.601, BT.709, BT.2020, limited then full.
    int coef_table [6][10] = '{
        '{66, 129, 25, -38, -74, 112, 112, -94, -18, 16},
        '{77, 150, 29, -43, -85, 128, 128, -107, -21, 0},
        '{47, 157, 16, -26, -86, 112, 112, -102, -10, 16},
        '{54, 183, 19, -29, -99, 128, 128, -116, -12, 0},
        '{58, 149, 13, -31, -81, 112, 112, -103, -9, 16},
        '{67, 174, 15, -36, -92, 128, 128, -118, -10, 0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the configuration, at its reset values.
    logic [CFG_DATA_W-1:0] cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    logic [1:0]            cfg_matrix = MAT_BT601;
    logic                  cfg_full   = 1'b0;
    logic                  cfg_swap   = 1'b0;

    // Predictor copy of the raster state and the even-row pair sums.
    int col_pos   = 0;
    int row_pos   = 0;
    int held_red  = 0;
    int held_green = 0;
    int held_blue = 0;
    int line_red   [LINE_SLOTS];
    int line_green [LINE_SLOTS];
    int line_blue  [LINE_SLOTS];

    yuv_result_t expected_pixels[$];

    int pixels_sent     = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int stall_left      = 0;
    int hold_off_cycles = 0;
    bit gaps_enabled    = 1'b1;

    rgba_to_yuv420_convert_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int clip_byte(input int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic int clamp_dim(input int v, input int limit);
        return (v < 1) ? 1 : (v > limit) ? limit : v;
    endfunction

    // Weighted sum with rounding; the shift floors negative sums.
    function automatic int weighted_round(input int set, input int base, input int red,
                                          input int green, input int blue);
        return (coef_table[set][base] * red + coef_table[set][base + 1] * green
                + coef_table[set][base + 2] * blue + 128) >>> 8;
    endfunction

    function automatic yuv_result_t predict_pixel(input logic [23:0] data, input int serial);
        yuv_result_t res;
        int red, green, blue, width, height, set, slot;
        int pair_r, pair_g, pair_b, sum_r, sum_g, sum_b;
        bit last_col, last_row, have_pair;
        red    = int'(cfg_swap ? data[23:16] : data[7:0]);
        green  = int'(data[15:8]);
        blue   = int'(cfg_swap ? data[7:0] : data[23:16]);
        width  = clamp_dim(int'(cfg_width), DEF_MAX_WIDTH);
        height = clamp_dim(int'(cfg_height), DEF_MAX_HEIGHT);
        set    = int'(cfg_full);
        if (cfg_matrix != MAT_SPARE) begin
            set += 2 * int'(cfg_matrix);
        end
        last_col  = (col_pos >= width - 1);
        last_row  = (row_pos >= height - 1);
        slot      = (col_pos / 2) % LINE_SLOTS;
        have_pair = 1'b0;
        pair_r    = 0;
        pair_g    = 0;
        pair_b    = 0;

        res.serial       = serial;
        res.luma         = 8'(clip_byte(weighted_round(set, Y_SLOT, red, green, blue)
                                        + coef_table[set][OFFSET_SLOT]));
        res.chroma_valid = 1'b0;
        res.blue_diff    = '0;
        res.red_diff     = '0;
        res.cell_column  = '0;
        res.cell_row     = '0;
        res.frame_done   = 1'b0;

        // Horizontal pair: odd column joins the held pixel, an even last
        // column pairs with itself.
        if (col_pos % 2 == 1) begin
            pair_r    = held_red + red;
            pair_g    = held_green + green;
            pair_b    = held_blue + blue;
            have_pair = 1'b1;
        end else begin
            held_red   = red;
            held_green = green;
            held_blue  = blue;
            if (last_col) begin
                pair_r    = 2 * red;
                pair_g    = 2 * green;
                pair_b    = 2 * blue;
                have_pair = 1'b1;
            end
        end

        if (have_pair) begin
            if (row_pos % 2 == 1 || last_row) begin
                if (row_pos % 2 == 1) begin
                    sum_r = line_red[slot] + pair_r;
                    sum_g = line_green[slot] + pair_g;
                    sum_b = line_blue[slot] + pair_b;
                end else begin
                    // Even last row: the row below is a copy of this one.
                    sum_r = 2 * pair_r;
                    sum_g = 2 * pair_g;
                    sum_b = 2 * pair_b;
                end
                sum_r = (sum_r + 2) >> 2;
                sum_g = (sum_g + 2) >> 2;
                sum_b = (sum_b + 2) >> 2;
                res.chroma_valid = 1'b1;
                res.blue_diff    = 8'(clip_byte(weighted_round(set, CB_SLOT, sum_r, sum_g, sum_b)
                                                + CHROMA_MID));
                res.red_diff     = 8'(clip_byte(weighted_round(set, CR_SLOT, sum_r, sum_g, sum_b)
                                                + CHROMA_MID));
                res.cell_column  = 11'(col_pos / 2);
                res.cell_row     = 11'(row_pos / 2);
            end else begin
                line_red[slot]   = pair_r;
                line_green[slot] = pair_g;
                line_blue[slot]  = pair_b;
            end
        end

        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos        = 0;
                res.frame_done = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // Keep the log readable when something breaks on every beat.
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int serial,
                               input logic [15:0] got, input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("pixel %0d: %s is %0d, expected %0d",
                                      serial, name, got, want));
        end
    endtask

    // A long hold-off requested by a test takes priority over the per-beat
    // stall drawn after each result.
    always @(negedge aclk) begin : result_ready_drive
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        yuv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result beat arrived with no pixel outstanding");
            end else begin
                want = expected_pixels.pop_front();
                check_field("luma", want.serial, 16'(m_tdata[7:0]), 16'(want.luma));
                check_field("chroma_valid", want.serial, 16'(m_tuser),
                            16'(want.chroma_valid));
                check_field("blue_diff", want.serial, 16'(m_tdata[15:8]),
                            16'(want.blue_diff));
                check_field("red_diff", want.serial, 16'(m_tdata[23:16]),
                            16'(want.red_diff));
                check_field("cell_column", want.serial, 16'(m_tdata[34:24]),
                            16'(want.cell_column));
                check_field("cell_row", want.serial, 16'(m_tdata[45:35]),
                            16'(want.cell_row));
                check_field("frame_done", want.serial, 16'(m_tlast),
                            16'(want.frame_done));
                check_field("padding", want.serial, 16'(m_tdata[47:46]), '0);
            end
            stall_left = gaps_enabled ? $urandom_range(0, 19) : 0;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        return {random_byte(), random_byte(), random_byte()};
    endfunction

    // s_tvalid stays high after a beat until the next falling edge, where
    // either the next pixel or a gap replaces it.
    task automatic send_pixel(input logic [23:0] data);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_pixels.push_back(predict_pixel(data, pixels_sent));
        pixels_sent++;
    endtask

    // Stops the input and waits until every predicted result has come back,
    // then keeps watching the result side so a stray beat would still be seen.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (index)
            REG_FRAME_WIDTH:   cfg_width  = CFG_DATA_W'(value);
            REG_FRAME_HEIGHT:  cfg_height = CFG_DATA_W'(value);
            REG_MATRIX_SELECT: cfg_matrix = 2'(value);
            REG_FULL_RANGE:    cfg_full   = value[0];
            REG_SWAP_RB:       cfg_swap   = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame_size(input int width, input int height);
        write_register(REG_FRAME_WIDTH, width);
        write_register(REG_FRAME_HEIGHT, height);
    endtask

    task automatic set_format(input logic [1:0] matrix, input logic full, input logic swap);
        write_register(REG_MATRIX_SELECT, int'(matrix));
        write_register(REG_FULL_RANGE, int'(full));
        write_register(REG_SWAP_RB, int'(swap));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_pixel_extremes();
        // Odd width and odd height, so the right column and the bottom row
        // close their cells by replicating the edge.
        set_frame_size(3, 3);
        set_format(MAT_BT601, 1'b0, 1'b0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'h808080);
        send_pixel(24'h5AA501);
        send_pixel(24'h7F807F);
        send_pixel(24'hC3963C);
        drain_results();

        // Full range with BGRA input: a solid blue cell and a solid red cell
        // push Cb and Cr past 255, so both clip.
        set_frame_size(4, 2);
        set_format(MAT_BT709, 1'b1, 1'b1);
        repeat (2) begin
            send_pixel(24'h0000FF);
            send_pixel(24'h0000FF);
            send_pixel(24'hFF0000);
            send_pixel(24'hFF0000);
        end
        drain_results();

        // One-pixel frame under the spare matrix code.
        set_frame_size(1, 1);
        set_format(MAT_SPARE, 1'b0, 1'b0);
        send_pixel(24'h123456);
        drain_results();

        // Zero dimensions act as one, so each pixel is a frame of its own.
        set_frame_size(0, 0);
        set_format(MAT_BT2020, 1'b0, 1'b0);
        send_pixel(24'hFEDCBA);
        send_pixel(24'h010203);
        drain_results();
    endtask

    task automatic test_dimension_limits();
        // Both sizes saturate to the maximum.
        set_frame_size(8191, 8191);
        set_format(MAT_BT2020, 1'b1, 1'b0);
        repeat (13) send_pixel(random_pixel());
        drain_results();

        // Shrinking the width in the middle of row 0: the raster position is
        // already past the new edge, so the next beat ends the row. Row 1
        // then only reads pair sums that row 0 wrote.
        write_register(REG_FRAME_WIDTH, 6);
        repeat (7) send_pixel(random_pixel());
        drain_results();

        // A height of zero acts as one, so even row 2 becomes the last row.
        write_register(REG_FRAME_HEIGHT, 0);
        repeat (6) send_pixel(random_pixel());
        drain_results();
    endtask

    task automatic test_long_lines();
        // A long single row of odd width runs many chroma columns back to
        // back; a one-pixel wide frame of many rows closes a cell on every
        // second row.
        set_format(MAT_BT709, 1'b0, 1'b0);
        set_frame_size(LONG_ROW, 1);
        gaps_enabled = 1'b0;
        repeat (LONG_ROW) send_pixel(random_pixel());
        drain_results();
        gaps_enabled = 1'b1;
        set_frame_size(1, TALL_COLUMN);
        repeat (TALL_COLUMN) send_pixel(random_pixel());
        drain_results();
    endtask

    task automatic test_output_backpressure();
        // The result side holds off long enough for the queue to fill while
        // the input keeps offering beats back to back.
        set_frame_size(6, 4);
        set_format(MAT_BT601, 1'b1, 1'b0);
        gaps_enabled = 1'b0;
        @(posedge aclk);
        hold_off_cycles = 200;
        repeat (24) send_pixel(random_pixel());
        // Pause the input until every result of the first frame is back.
        drain_results();
        gaps_enabled = 1'b1;
        repeat (24) send_pixel(random_pixel());
        drain_results();
    endtask

    task automatic test_random_frames();
        int width, height, pixels, split, sent;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: begin
                    width  = $urandom_range(11, 64);
                    height = $urandom_range(1, 3);
                end
                1: begin
                    width  = $urandom_range(1, 3);
                    height = $urandom_range(7, 20);
                end
                default: begin
                    width  = $urandom_range(1, 10);
                    height = $urandom_range(1, 6);
                end
            endcase
            set_frame_size(width, height);
            set_format(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            gaps_enabled = ($urandom_range(0, 3) != 0);
            pixels = width * height;
            split  = 0;
            if (pixels > 1 && $urandom_range(0, 2) == 0) begin
                split = $urandom_range(1, pixels - 1);
            end
            for (int i = 0; i < pixels; i++) begin
                // Format change in the middle of the frame: the raster
                // position, the held pixel and the line store carry over.
                if (split != 0 && i == split) begin
                    drain_results();
                    set_format(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
                send_pixel(random_pixel());
            end
            sent += pixels;
            drain_results();
        end
        gaps_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_pixel_extremes();
        test_dimension_limits();
        test_long_lines();
        test_output_backpressure();
        test_random_frames();
        drain_results();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/r2y_pkg.sv
design/r2y_ram.sv
design/r2y_fifo.sv
design/r2y_front.sv
design/r2y_back.sv
design/rgba_to_yuv420_convert_core.sv
tb/rgba_to_yuv420_convert_core_tb.sv
